[design/msc_pkg.sv]
// Package: widths, count codes and controller/datapath interface types for the square-count unit
package msc_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int ROOT_WIDTH  = (VALUE_WIDTH + 1) / 2;
   localparam int PROD_WIDTH  = 2 * ROOT_WIDTH;
   localparam int IDX_WIDTH   = ROOT_WIDTH + 1;
   localparam int SQ_WIDTH    = VALUE_WIDTH + 1;
   localparam int SUM_WIDTH   = VALUE_WIDTH + 2;
   localparam int COUNT_WIDTH = 3;

   localparam logic [COUNT_WIDTH-1:0] COUNT_ZERO  = 3'd0;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE   = 3'd1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_TWO   = 3'd2;
   localparam logic [COUNT_WIDTH-1:0] COUNT_THREE = 3'd3;
   localparam logic [COUNT_WIDTH-1:0] COUNT_FOUR  = 3'd4;

   typedef struct packed {
      logic                   load;
      logic                   root_step;
      logic                   pair_init;
      logic                   pair_step;
      logic                   strip_step;
      logic                   finish;
      logic [COUNT_WIDTH-1:0] count;
   } msc_cmd_type;

   typedef struct packed {
      logic zero;
      logic root_last;
      logic is_square;
      logic pair_over;
      logic pair_hit;
      logic strip_done;
      logic low_seven;
      logic out_busy;
   } msc_status_type;

endpackage

[design/msc_ctrl.sv]
// Controller: sequences root search, pair search and power-of-four strip for one request
module msc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  msc_pkg::msc_status_type stat,
   output msc_pkg::msc_cmd_type    cmd
);
   import msc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ROOT  = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_PAIR  = 5'b01000,
      ST_STRIP = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.count = COUNT_ZERO;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (stat.root_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.zero || stat.is_square) begin
               if (!stat.out_busy) begin
                  cmd.finish = 1'b1;
                  cmd.count  = stat.zero ? COUNT_ZERO : COUNT_ONE;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.pair_init = 1'b1;
               state_in      = ST_PAIR;
            end
         end
         ST_PAIR: begin
            if (stat.pair_over) begin
               state_in = ST_STRIP;
            end else if (stat.pair_hit) begin
               if (!stat.out_busy) begin
                  cmd.finish = 1'b1;
                  cmd.count  = COUNT_TWO;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.pair_step = 1'b1;
            end
         end
         ST_STRIP: begin
            if (stat.strip_done) begin
               if (!stat.out_busy) begin
                  cmd.finish = 1'b1;
                  cmd.count  = stat.low_seven ? COUNT_FOUR : COUNT_THREE;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.strip_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !stat.out_busy)
      else $error("result issued while output register still occupied");

   a_load_to_root: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_ROOT))
      else $error("accepted request did not start root search");

endmodule

[design/msc_datapath.sv]
// Datapath: bit-serial square root, two-pointer pair search, factor-of-four strip, result register
module msc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [msc_pkg::VALUE_WIDTH-1:0]     req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [msc_pkg::COUNT_WIDTH-1:0]     rsp_square_count,
   input  msc_pkg::msc_cmd_type                cmd,
   output msc_pkg::msc_status_type             stat
);
   import msc_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [ROOT_WIDTH-1:0]  root_ff, root_in;
   logic [ROOT_WIDTH-1:0]  root_bit_ff;
   logic [PROD_WIDTH-1:0]  rsq_ff, rsq_in;
   logic [IDX_WIDTH-1:0]   a_ff, b_ff;
   logic [SQ_WIDTH-1:0]    asq_ff, bsq_ff;
   logic [VALUE_WIDTH-1:0] m_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;

   logic [ROOT_WIDTH-1:0]  trial;
   logic [PROD_WIDTH-1:0]  trial_sq;
   logic [SUM_WIDTH-1:0]   pair_sum;
   logic [SUM_WIDTH-1:0]   value_ext;

   assign trial     = root_ff | root_bit_ff;
   assign trial_sq  = PROD_WIDTH'(trial) * PROD_WIDTH'(trial);
   assign pair_sum  = SUM_WIDTH'(asq_ff) + SUM_WIDTH'(bsq_ff);
   assign value_ext = SUM_WIDTH'(value_ff);

   always_comb begin
      root_in = root_ff;
      rsq_in  = rsq_ff;
      if (trial_sq <= PROD_WIDTH'(value_ff)) begin
         root_in = trial;
         rsq_in  = trial_sq;
      end
   end

   assign stat.zero       = (value_ff == '0);
   assign stat.root_last  = root_bit_ff[0];
   assign stat.is_square  = (rsq_ff == PROD_WIDTH'(value_ff));
   assign stat.pair_over  = (a_ff > b_ff);
   assign stat.pair_hit   = (pair_sum == value_ext);
   assign stat.strip_done = (m_ff[1:0] != 2'b00);
   assign stat.low_seven  = (m_ff[2:0] == 3'b111);
   assign stat.out_busy   = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff    <= req_value;
         m_ff        <= req_value;
         root_ff     <= '0;
         rsq_ff      <= '0;
         root_bit_ff <= {1'b1, {(ROOT_WIDTH-1){1'b0}}};
      end else if (cmd.root_step) begin
         root_ff     <= root_in;
         rsq_ff      <= rsq_in;
         root_bit_ff <= root_bit_ff >> 1;
      end else if (cmd.strip_step) begin
         m_ff <= m_ff >> 2;
      end
      if (cmd.pair_init) begin
         a_ff   <= IDX_WIDTH'(1);
         asq_ff <= SQ_WIDTH'(1);
         b_ff   <= IDX_WIDTH'(root_ff);
         bsq_ff <= SQ_WIDTH'(rsq_ff);
      end else if (cmd.pair_step) begin
         if (pair_sum < value_ext) begin
            a_ff   <= a_ff + IDX_WIDTH'(1);
            asq_ff <= asq_ff + SQ_WIDTH'({a_ff, 1'b1});
         end else begin
            b_ff   <= b_ff - IDX_WIDTH'(1);
            bsq_ff <= bsq_ff - SQ_WIDTH'({b_ff, 1'b0}) + SQ_WIDTH'(1);
         end
      end
      if (cmd.finish) begin
         rsp_count_ff <= cmd.count;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_square_count = rsp_count_ff;

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.root_step |=> (rsq_ff <= PROD_WIDTH'(value_ff)))
      else $error("root square exceeds value");

   a_pair_square: assert property (@(posedge clock) disable iff (reset)
      cmd.pair_step |=> (SUM_WIDTH'(asq_ff) == SUM_WIDTH'(a_ff) * SUM_WIDTH'(a_ff)))
      else $error("running square of lower index out of step");

endmodule

[design/min_square_sum_count_unit.sv]
// Top level: least count of perfect squares summing to the request value
// Sequence: bit-serial root search, a square check, the two-pointer pair search, then the
// power-of-four strip; a finished result waits while the output register is still occupied.
// One request at a time: a new request is accepted only while the controller is idle.
// The result register lets the next request start while a result waits.
// Reset clears the controller state and the result valid flag.
module min_square_sum_count_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [msc_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [msc_pkg::COUNT_WIDTH-1:0] rsp_square_count
);
   import msc_pkg::*;

   msc_cmd_type    cmd;
   msc_status_type stat;

   msc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   msc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_square_count (rsp_square_count),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule
